// File: hw/rtl/fdcg_pkg.sv
`default_nettype none

package fdcg_pkg;

  // frame buffer
  localparam int unsigned BUF_LIMIT = 64;
  localparam int unsigned LEN_W     = 7;
  localparam logic [LEN_W-1:0] LEN_MAX = 7'd127;

  // keyword matchers
  localparam int unsigned KW_COUNT = 5;
  localparam int unsigned KW_FWD   = 0;
  localparam int unsigned KW_BWD   = 1;
  localparam int unsigned KW_LEFT  = 2;
  localparam int unsigned KW_RIGHT = 3;
  localparam int unsigned KW_STOP  = 4;

  // special characters
  localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
  localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
  localparam logic [7:0] CH_NL    = 8'h0A;  // '\n'

  // drive modes
  localparam logic [2:0] M_STOP  = 3'd0;
  localparam logic [2:0] M_FWD   = 3'd1;
  localparam logic [2:0] M_BWD   = 3'd2;
  localparam logic [2:0] M_LEFT  = 3'd3;
  localparam logic [2:0] M_RIGHT = 3'd4;

  // bridge directions
  localparam logic [1:0] DIR_OFF = 2'd0;
  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_REV = 2'd2;

  // event codes
  localparam logic [3:0] EV_NONE    = 4'd0;
  localparam logic [3:0] EV_FWD     = 4'd1;
  localparam logic [3:0] EV_BWD     = 4'd2;
  localparam logic [3:0] EV_LEFT    = 4'd3;
  localparam logic [3:0] EV_RIGHT   = 4'd4;
  localparam logic [3:0] EV_STOP    = 4'd5;
  localparam logic [3:0] EV_REFUSED = 4'd6;
  localparam logic [3:0] EV_UNKNOWN = 4'd7;
  localparam logic [3:0] EV_TIMEOUT = 4'd8;

  // register indexes
  localparam logic [1:0] REG_OBSTACLE_CM = 2'd0;
  localparam logic [1:0] REG_DRIVE_SPEED = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_MS  = 2'd2;

  // register reset values
  localparam logic [7:0]  OBSTACLE_CM_RST = 8'd15;
  localparam logic [7:0]  DRIVE_SPEED_RST = 8'd200;
  localparam logic [15:0] TIMEOUT_MS_RST  = 16'd500;

  // echo_us * 343 <= obstacle_cm * 20000 is the exact form of us * 0.0343 / 2 <= cm
  localparam int unsigned ECHO_SCALE = 343;
  localparam int unsigned OBST_SCALE = 20000;
  localparam int unsigned LIM_W      = 23;
  localparam int unsigned PROD_W     = 24;

  // x / 3 for 8-bit x as (x * 171) >> 9
  localparam int unsigned THIRD_MUL   = 171;
  localparam int unsigned THIRD_SHIFT = 9;

  function automatic logic [3:0] kw_len(input logic [2:0] k);
    logic [3:0] n;
    case (k)
      3'd0:    n = 4'd7;
      3'd1:    n = 4'd7;
      3'd2:    n = 4'd8;
      3'd3:    n = 4'd9;
      3'd4:    n = 4'd8;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] p);
    logic [7:0] c;
    c = 8'h00;
    if (p < 4'd4) begin
      case (p)
        4'd0:    c = (k == 3'd4) ? "C" : "D";
        4'd1:    c = (k == 3'd4) ? "M" : "I";
        4'd2:    c = (k == 3'd4) ? "D" : "R";
        default: c = ":";
      endcase
    end else begin
      case (k)
        3'd0: begin
          case (p)
            4'd4:    c = "F";
            4'd5:    c = "W";
            4'd6:    c = "D";
            default: c = 8'h00;
          endcase
        end
        3'd1: begin
          case (p)
            4'd4:    c = "B";
            4'd5:    c = "W";
            4'd6:    c = "D";
            default: c = 8'h00;
          endcase
        end
        3'd2: begin
          case (p)
            4'd4:    c = "L";
            4'd5:    c = "E";
            4'd6:    c = "F";
            4'd7:    c = "T";
            default: c = 8'h00;
          endcase
        end
        3'd3: begin
          case (p)
            4'd4:    c = "R";
            4'd5:    c = "I";
            4'd6:    c = "G";
            4'd7:    c = "H";
            4'd8:    c = "T";
            default: c = 8'h00;
          endcase
        end
        3'd4: begin
          case (p)
            4'd4:    c = "S";
            4'd5:    c = "T";
            4'd6:    c = "O";
            4'd7:    c = "P";
            default: c = 8'h00;
          endcase
        end
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/framed_drive_command_guard.sv
// framed drive command guard
//
// input channel (in_*): one word per received serial character (in_tuser 0)
// or per millisecond tick (in_tuser 1); in_tdata carries the character and
// the current ultrasonic echo width in microseconds
// result channel (out_*): exactly one word per input word, in order, giving
// both motor duties, both bridge directions and the event of that word
// config port (cfg_*): obstacle distance, drive speed and timeout, written
// at any edge with cfg_we high; meant to be written while the block is idle
//
// path: an accepted word passes from the input register through the update stage into the result register
// throughput: one word per cycle while out_tready is high, set by the single state
// update stage that sits between the input register and the result register
// stall: while out_tready is low the result register holds, the input
// register takes one more word, then in_tready drops until the result drains
// reset (rst_n low, synchronous): both registers empty, frame state and
// timer cleared, motors stopped, config back to 15 cm / 200 / 500 ms
`default_nettype none

module framed_drive_command_guard
  import fdcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // byte_value[7:0], echo_us[22:8], zero[23]
  input  wire logic [0:0]  in_tuser,   // func[0]: 0 character, 1 tick

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0] out_tdata,       // left_duty[7:0], right_duty[15:8],
                                       // left_dir[17:16], right_dir[19:18],
                                       // event_res[23:20]

  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  // config registers; obstacle distance kept pre-scaled for the compare
  logic [LIM_W-1:0] obst_lim_r;
  logic [7:0]       speed_r;
  logic [15:0]      timeout_r;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_func_r;
  logic [7:0]  s1_byte_r;
  logic [14:0] s1_echo_r;

  // frame and drive state
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             open_r, open_nxt;
  logic             close_r, close_nxt;
  logic [3:0]       prog_r [KW_COUNT];
  logic [3:0]       prog_nxt [KW_COUNT];
  logic [KW_COUNT-1:0] found_r, found_nxt;
  logic [15:0]      elapsed_r, elapsed_nxt;
  logic [2:0]       mode_r, mode_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;

  logic advance;

  // working values of the update stage
  logic [LEN_W-1:0]    len_inc;
  logic                open_f, close_f;
  logic [3:0]          prog_f [KW_COUNT];
  logic [KW_COUNT-1:0] found_f;
  logic [3:0]          p_tmp;
  logic                is_term;
  logic [PROD_W-1:0]   echo_prod;
  logic                blocked;
  logic [3:0]          ev;
  logic [16:0]         third_prod;
  logic [7:0]          third;
  logic [7:0]          ld, rd;
  logic [1:0]          ldir, rdir;

  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // exact obstacle test
  assign echo_prod = PROD_W'(s1_echo_r) * PROD_W'(ECHO_SCALE);
  assign blocked   = (s1_echo_r != 15'd0) && (echo_prod <= PROD_W'(obst_lim_r));

  // inner wheel speed of a turn
  assign third_prod = 17'(speed_r) * 17'(THIRD_MUL);
  assign third      = third_prod[THIRD_SHIFT +: 8];

  assign s1_valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // character matching: each keyword restarts at its first letter on a miss
  always_comb begin
    len_inc = (len_r < LEN_MAX) ? len_r + 7'd1 : len_r;
    open_f  = open_r  || (s1_byte_r == CH_OPEN);
    close_f = close_r || (s1_byte_r == CH_CLOSE);
    is_term = (s1_byte_r == CH_NL) || (s1_byte_r == CH_CLOSE);
    found_f = found_r;
    p_tmp   = 4'd0;
    for (int k = 0; k < KW_COUNT; k++) begin
      p_tmp = prog_r[k];
      if (p_tmp < kw_len(3'(k)) && s1_byte_r == kw_char(3'(k), p_tmp)) begin
        p_tmp = p_tmp + 4'd1;
      end else begin
        p_tmp = (s1_byte_r == kw_char(3'(k), 4'd0)) ? 4'd1 : 4'd0;
      end
      if (p_tmp >= kw_len(3'(k))) begin
        found_f[k] = 1'b1;
        p_tmp      = 4'd0;
      end
      prog_f[k] = p_tmp;
    end
  end

  // state update for the word in the input register
  always_comb begin
    len_nxt     = len_r;
    open_nxt    = open_r;
    close_nxt   = close_r;
    found_nxt   = found_r;
    elapsed_nxt = elapsed_r;
    mode_nxt    = mode_r;
    ev          = EV_NONE;
    for (int k = 0; k < KW_COUNT; k++) begin
      prog_nxt[k] = prog_r[k];
    end
    if (advance) begin
      if (!s1_func_r) begin
        len_nxt   = len_inc;
        open_nxt  = open_f;
        close_nxt = close_f;
        found_nxt = found_f;
        for (int k = 0; k < KW_COUNT; k++) begin
          prog_nxt[k] = prog_f[k];
        end
        if (is_term) begin
          if (open_f && close_f) begin
            // complete frame: run the highest priority keyword
            elapsed_nxt = 16'd0;
            if (found_f[KW_FWD]) begin
              if (blocked) begin
                ev = EV_REFUSED;
              end else begin
                mode_nxt = M_FWD;
                ev       = EV_FWD;
              end
            end else if (found_f[KW_BWD]) begin
              mode_nxt = M_BWD;
              ev       = EV_BWD;
            end else if (found_f[KW_LEFT]) begin
              mode_nxt = M_LEFT;
              ev       = EV_LEFT;
            end else if (found_f[KW_RIGHT]) begin
              mode_nxt = M_RIGHT;
              ev       = EV_RIGHT;
            end else if (found_f[KW_STOP]) begin
              mode_nxt = M_STOP;
              ev       = EV_STOP;
            end else begin
              ev = EV_UNKNOWN;
            end
            len_nxt   = '0;
            open_nxt  = 1'b0;
            close_nxt = 1'b0;
            found_nxt = '0;
            for (int k = 0; k < KW_COUNT; k++) begin
              prog_nxt[k] = 4'd0;
            end
          end
        end else if (len_inc > LEN_W'(BUF_LIMIT)) begin
          // overlong frame is dropped
          len_nxt   = '0;
          open_nxt  = 1'b0;
          close_nxt = 1'b0;
          found_nxt = '0;
          for (int k = 0; k < KW_COUNT; k++) begin
            prog_nxt[k] = 4'd0;
          end
        end
      end else begin
        if (elapsed_r != 16'hFFFF) begin
          elapsed_nxt = elapsed_r + 16'd1;
        end
        if (elapsed_nxt > timeout_r) begin
          mode_nxt = M_STOP;
          ev       = EV_TIMEOUT;
        end
      end
    end
  end

  // motor outputs from the mode after this word
  always_comb begin
    ld   = 8'd0;
    rd   = 8'd0;
    ldir = DIR_OFF;
    rdir = DIR_OFF;
    unique case (mode_nxt)
      M_FWD: begin
        ld = speed_r; rd = speed_r; ldir = DIR_FWD; rdir = DIR_FWD;
      end
      M_BWD: begin
        ld = speed_r; rd = speed_r; ldir = DIR_REV; rdir = DIR_REV;
      end
      M_LEFT: begin
        ld = third; rd = speed_r; ldir = DIR_FWD; rdir = DIR_FWD;
      end
      M_RIGHT: begin
        ld = speed_r; rd = third; ldir = DIR_FWD; rdir = DIR_FWD;
      end
      default: begin
        ld = 8'd0;
      end
    endcase
    out_data_nxt = advance ? {ev, rdir, ldir, rd, ld} : out_data_r;
  end

  // control, state and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      len_r       <= '0;
      open_r      <= 1'b0;
      close_r     <= 1'b0;
      found_r     <= '0;
      elapsed_r   <= 16'd0;
      mode_r      <= M_STOP;
      for (int k = 0; k < KW_COUNT; k++) begin
        prog_r[k] <= 4'd0;
      end
      obst_lim_r  <= LIM_W'(OBSTACLE_CM_RST) * LIM_W'(OBST_SCALE);
      speed_r     <= DRIVE_SPEED_RST;
      timeout_r   <= TIMEOUT_MS_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
      open_r      <= open_nxt;
      close_r     <= close_nxt;
      found_r     <= found_nxt;
      elapsed_r   <= elapsed_nxt;
      mode_r      <= mode_nxt;
      for (int k = 0; k < KW_COUNT; k++) begin
        prog_r[k] <= prog_nxt[k];
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_OBSTACLE_CM: obst_lim_r <= LIM_W'(cfg_wdata[7:0]) * LIM_W'(OBST_SCALE);
          REG_DRIVE_SPEED: speed_r    <= cfg_wdata[7:0];
          REG_TIMEOUT_MS:  timeout_r  <= cfg_wdata;
          default:         ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_func_r <= in_tuser[0];
      s1_byte_r <= in_tdata[7:0];
      s1_echo_r <= in_tdata[22:8];
    end
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/fdcg_checker.sv
`default_nettype none

module fdcg_checker
  import fdcg_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // no result word right after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

  // both bridges are off together
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[17:16] == DIR_OFF) == (out_tdata[19:18] == DIR_OFF)))
    else $error("one bridge off, other driven");

  // off bridges carry zero duty
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17:16] == DIR_OFF |-> out_tdata[15:0] == 16'd0)
    else $error("duty while stopped");

  // a timeout always leaves the motors stopped
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23:20] == EV_TIMEOUT |-> out_tdata[19:16] == 4'd0)
    else $error("motors running after timeout");

endmodule

bind framed_drive_command_guard fdcg_checker u_fdcg_checker (.*);

`default_nettype wire

// File: dv/drive_guard_checker.sv
`timescale 1ns / 1ps

module drive_guard_checker
  import fdcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,   // byte_value[7:0], echo_us[22:8], zero[23]
  input  wire logic [0:0]  in_tuser,   // func[0]

  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,  // left_duty, right_duty, left_dir, right_dir,
                                       // event_res (lowest bits first)

  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,

  output int unsigned      fail_count,
  output int unsigned      words_pending,
  output int unsigned      words_checked,
  output logic [8:0]       events_seen
);

  typedef struct packed {
    logic [3:0] ev;
    logic [1:0] right_dir;
    logic [1:0] left_dir;
    logic [7:0] right_duty;
    logic [7:0] left_duty;
  } drive_word_t;

  // predicted motor words, oldest first
  drive_word_t pending_drive[$];

  logic [7:0]  obstacle_cm;
  logic [7:0]  drive_speed;
  logic [15:0] timeout_ms;

  logic [6:0]  frame_len;
  logic        open_seen;
  logic        close_seen;
  int          kw_progress [KW_COUNT];
  logic        kw_found    [KW_COUNT];
  logic [15:0] elapsed_ms;
  logic [2:0]  drive_mode;

  string kw_pattern [KW_COUNT];

  initial begin
    kw_pattern[KW_FWD]   = "DIR:FWD";
    kw_pattern[KW_BWD]   = "DIR:BWD";
    kw_pattern[KW_LEFT]  = "DIR:LEFT";
    kw_pattern[KW_RIGHT] = "DIR:RIGHT";
    kw_pattern[KW_STOP]  = "CMD:STOP";
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at word %0d, %s: got %0d, expected %0d",
             words_checked, what, got, want);
    fail_count++;
  endtask

  task automatic clear_frame();
    frame_len  = '0;
    open_seen  = 1'b0;
    close_seen = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_progress[k] = 0;
      kw_found[k]    = 1'b0;
    end
  endtask

  task automatic predict_drive(input logic tick, input logic [7:0] ch,
                               input logic [14:0] echo);
    drive_word_t w;
    logic [7:0]  third;
    logic        blocked;
    int          p;
    w = '0;
    if (!tick) begin
      if (frame_len != LEN_MAX) frame_len++;
      if (ch == CH_OPEN)  open_seen  = 1'b1;
      if (ch == CH_CLOSE) close_seen = 1'b1;
      for (int k = 0; k < KW_COUNT; k++) begin
        p = kw_progress[k];
        if (p < kw_pattern[k].len() && ch == kw_pattern[k][p]) p++;
        else p = (ch == kw_pattern[k][0]) ? 1 : 0;
        if (p >= kw_pattern[k].len()) begin
          kw_found[k] = 1'b1;
          p = 0;
        end
        kw_progress[k] = p;
      end
      if (ch == CH_NL || ch == CH_CLOSE) begin
        if (open_seen && close_seen) begin
          blocked = (echo != '0) &&
                    (32'(echo) * ECHO_SCALE <= 32'(obstacle_cm) * OBST_SCALE);
          elapsed_ms = '0;
          if (kw_found[KW_FWD]) begin
            if (blocked) w.ev = EV_REFUSED;
            else begin
              drive_mode = M_FWD;
              w.ev = EV_FWD;
            end
          end else if (kw_found[KW_BWD]) begin
            drive_mode = M_BWD;
            w.ev = EV_BWD;
          end else if (kw_found[KW_LEFT]) begin
            drive_mode = M_LEFT;
            w.ev = EV_LEFT;
          end else if (kw_found[KW_RIGHT]) begin
            drive_mode = M_RIGHT;
            w.ev = EV_RIGHT;
          end else if (kw_found[KW_STOP]) begin
            drive_mode = M_STOP;
            w.ev = EV_STOP;
          end else begin
            w.ev = EV_UNKNOWN;
          end
          clear_frame();
        end
      end else if (frame_len > BUF_LIMIT) begin
        clear_frame();
      end
    end else begin
      if (elapsed_ms != 16'hFFFF) elapsed_ms++;
      if (elapsed_ms > timeout_ms) begin
        drive_mode = M_STOP;
        w.ev = EV_TIMEOUT;
      end
    end

    third = drive_speed / 8'd3;
    case (drive_mode)
      M_FWD: begin
        w.left_duty = drive_speed; w.right_duty = drive_speed;
        w.left_dir  = DIR_FWD;     w.right_dir  = DIR_FWD;
      end
      M_BWD: begin
        w.left_duty = drive_speed; w.right_duty = drive_speed;
        w.left_dir  = DIR_REV;     w.right_dir  = DIR_REV;
      end
      M_LEFT: begin
        w.left_duty = third;       w.right_duty = drive_speed;
        w.left_dir  = DIR_FWD;     w.right_dir  = DIR_FWD;
      end
      M_RIGHT: begin
        w.left_duty = drive_speed; w.right_duty = third;
        w.left_dir  = DIR_FWD;     w.right_dir  = DIR_FWD;
      end
      default: ;
    endcase
    pending_drive.push_back(w);
  endtask

  always @(posedge clk) begin : watch
    drive_word_t got;
    drive_word_t want;
    if (!rst_n) begin
      obstacle_cm = OBSTACLE_CM_RST;
      drive_speed = DRIVE_SPEED_RST;
      timeout_ms  = TIMEOUT_MS_RST;
      clear_frame();
      elapsed_ms  = '0;
      drive_mode  = M_STOP;
      pending_drive.delete();
      fail_count    = 0;
      words_checked = 0;
      events_seen   = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = drive_word_t'(out_tdata);
        if (pending_drive.size() == 0) begin
          report_mismatch("result with no word outstanding", out_tdata, 0);
        end else begin
          want = pending_drive.pop_front();
          if (got.left_duty != want.left_duty)
            report_mismatch("left_duty", got.left_duty, want.left_duty);
          if (got.right_duty != want.right_duty)
            report_mismatch("right_duty", got.right_duty, want.right_duty);
          if (got.left_dir != want.left_dir)
            report_mismatch("left_dir", got.left_dir, want.left_dir);
          if (got.right_dir != want.right_dir)
            report_mismatch("right_dir", got.right_dir, want.right_dir);
          if (got.ev != want.ev)
            report_mismatch("event_res", got.ev, want.ev);
          events_seen[want.ev] = 1'b1;
        end
        words_checked++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_OBSTACLE_CM: obstacle_cm = cfg_wdata[7:0];
          REG_DRIVE_SPEED: drive_speed = cfg_wdata[7:0];
          REG_TIMEOUT_MS:  timeout_ms  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_drive(in_tuser[0], in_tdata[7:0], in_tdata[22:8]);
    end
    words_pending <= pending_drive.size();
  end

endmodule

// File: dv/framed_drive_command_guard_tb.sv
`timescale 1ns / 1ps

module framed_drive_command_guard_tb;
  import fdcg_pkg::*;

  logic        clk;
  logic        rst_n      = 1'b0;

  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;    // byte_value[7:0], echo_us[22:8], zero[23]
  logic [0:0]  in_tuser   = '0;    // func[0]: 0 character, 1 tick

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // left_duty, right_duty, left_dir, right_dir,
                                   // event_res (lowest bits first)

  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = REG_OBSTACLE_CM;
  logic [15:0] cfg_wdata  = '0;

  int unsigned fail_count;
  int unsigned words_pending;
  int unsigned words_checked;
  logic [8:0]  events_seen;

  // sender bookkeeping
  int unsigned words_sent = 0;
  int          burst_left = 0;
  bit          tx_flat    = 1'b0;   // no gaps on the input side
  // receiver controls, written with nonblocking assignments
  logic        rx_flat     = 1'b0;  // receiver always ready
  int unsigned rx_hold_seq = 0;     // each bump asks for one long hold-off

  // obstacle distance currently programmed, for echo values near the limit
  logic [7:0]  cur_obst = OBSTACLE_CM_RST;

  string kw_cmd [KW_COUNT];

  initial begin
    kw_cmd[KW_FWD]   = "DIR:FWD";
    kw_cmd[KW_BWD]   = "DIR:BWD";
    kw_cmd[KW_LEFT]  = "DIR:LEFT";
    kw_cmd[KW_RIGHT] = "DIR:RIGHT";
    kw_cmd[KW_STOP]  = "CMD:STOP";
  end

  framed_drive_command_guard u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  drive_guard_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .words_checked (words_checked),
    .events_seen   (events_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // receiver: random stall segments, some with no stalls at all, plus a
  // long hold-off on request so the input side backs up and drops ready
  // ---------------------------------------------------------------------
  initial begin : receiver
    int unsigned holds_done;
    int unsigned hold_left;
    int unsigned seg_left;
    int unsigned stall_pct;
    holds_done = 0;
    hold_left  = 0;
    seg_left   = 0;
    stall_pct  = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done != rx_hold_seq) begin
        holds_done++;
        hold_left = 300;
      end
      if (rx_flat) begin
        out_tready <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(8, 64);
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 25;
            3:       stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        seg_left--;
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // value helpers
  // ---------------------------------------------------------------------

  // full 15-bit echo range, beyond the sensor's 30000 us too
  function automatic logic [14:0] any_echo();
    return 15'($urandom_range(0, 32767));
  endfunction

  // largest echo that still counts as an obstacle
  function automatic logic [14:0] obstacle_limit();
    return 15'((32'(cur_obst) * OBST_SCALE) / ECHO_SCALE);
  endfunction

  // echo for a frame terminator: no echo, right at the limit, or anything
  function automatic logic [14:0] term_echo();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return obstacle_limit();
      2:       return obstacle_limit() + 15'd1;
      default: return any_echo();
    endcase
  endfunction

  // any byte except the framing characters
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_OPEN || c == CH_CLOSE || c == CH_NL);
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------

  // one word; bursts of random length with random gaps between them
  task automatic send_word(input logic tick, input logic [7:0] ch,
                           input logic [14:0] echo);
    int gap;
    if (!tx_flat && burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, echo, ch};
    in_tuser  <= tick;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic send_char(input logic [7:0] ch, input logic [14:0] echo);
    send_word(1'b0, ch, echo);
  endtask

  task automatic send_tick();
    send_word(1'b1, 8'($urandom_range(0, 255)), any_echo());
  endtask

  // keyword text, optionally with one character spoiled; the odd tick may
  // fall between characters
  task automatic send_keyword(input int kw, input bit corrupt);
    int bad;
    bad = corrupt ? $urandom_range(0, kw_cmd[kw].len() - 1) : -1;
    for (int i = 0; i < kw_cmd[kw].len(); i++) begin
      if ($urandom_range(0, 19) == 0) send_tick();
      send_char((i == bad) ? noise_char() : 8'(kw_cmd[kw][i]), any_echo());
    end
  endtask

  // well-formed frame with random content: noise around zero, one or two
  // keywords, closed by '>' or, after an early stray '>', by a newline
  task automatic send_frame();
    int shape;
    shape = $urandom_range(0, 9);
    if (shape == 0) send_char(CH_CLOSE, any_echo());
    send_char(CH_OPEN, any_echo());
    repeat ($urandom_range(0, 3)) send_char(noise_char(), any_echo());
    if ($urandom_range(0, 5) != 0)
      send_keyword($urandom_range(0, KW_COUNT - 1), $urandom_range(0, 7) == 0);
    if ($urandom_range(0, 3) == 0)
      send_keyword($urandom_range(0, KW_COUNT - 1), 1'b0);
    repeat ($urandom_range(0, 2)) send_char(noise_char(), any_echo());
    // newline with only the open bracket seen: appended, frame kept
    if (shape == 1) send_char(CH_NL, any_echo());
    send_char((shape == 0) ? CH_NL : CH_CLOSE, term_echo());
  endtask

  task automatic send_chunk();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      send_frame();
    end else if (sel < 70) begin
      // tick runs, long enough to trip the shorter timeouts
      repeat ($urandom_range(1, 25)) send_tick();
    end else if (sel < 82) begin
      // raw bytes, framing characters included
      repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)), any_echo());
    end else if (sel < 87) begin
      // noise runs around the buffer limit, so the frame clears on the longer ones
      repeat ($urandom_range(60, 72)) send_char(noise_char(), any_echo());
    end else if (sel < 92) begin
      // keyword and close bracket with no open bracket
      send_keyword($urandom_range(0, KW_COUNT - 1), 1'b0);
      send_char(CH_CLOSE, term_echo());
    end else if (sel < 97) begin
      // open frame ended only by a newline: kept for a later terminator
      send_char(CH_OPEN, any_echo());
      send_keyword($urandom_range(0, KW_COUNT - 1), 1'b0);
      send_char(CH_NL, term_echo());
    end else begin
      send_char(CH_CLOSE, term_echo());
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned target;
    target = words_sent + n;
    while (words_sent < target) send_chunk();
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  // write all three registers on consecutive edges (block idle)
  task automatic set_regs(input logic [7:0] obst, input logic [7:0] speed,
                          input logic [15:0] tmo);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OBSTACLE_CM;
    cfg_wdata <= {8'h00, obst};
    @(posedge clk);
    cfg_index <= REG_DRIVE_SPEED;
    cfg_wdata <= {8'h00, speed};
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_MS;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_obst = obst;
  endtask

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 15 cm, speed 200, 500 ms
    // field extremes on both word kinds
    send_char(8'h00, 15'h0000);
    send_char(8'hFF, 15'h7FFF);
    send_word(1'b1, 8'hFF, 15'h7FFF);
    send_word(1'b1, 8'h00, 15'h0000);
    // forward with echo exactly at the obstacle limit: refused
    send_char(CH_OPEN, any_echo());
    send_keyword(KW_FWD, 1'b0);
    send_char(CH_CLOSE, obstacle_limit());
    // one microsecond further out: accepted
    send_char(CH_OPEN, any_echo());
    send_keyword(KW_FWD, 1'b0);
    send_char(CH_CLOSE, obstacle_limit() + 15'd1);
    // empty bracketed frame: unknown command
    send_char(CH_OPEN, any_echo());
    send_char(CH_CLOSE, 15'h0000);
    // newline with no brackets: appended only
    send_char(CH_NL, any_echo());

    // newline flood saturates the length count; the next plain byte clears
    repeat (130) send_char(CH_NL, any_echo());
    send_char("A", any_echo());

    // long receiver hold-off while the sender keeps offering words
    rx_hold_seq <= rx_hold_seq + 1;
    run_random(150);

    // no obstacle possible, full speed, timeout on every tick
    settle();
    set_regs(8'd0, 8'd255, 16'd0);
    run_random(100);

    // widest obstacle range, minimum nonzero speed (third rounds to 0)
    settle();
    set_regs(8'd255, 8'd1, 16'd40);
    run_random(110);

    // random settings with a second hold-off
    settle();
    set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             16'($urandom_range(5, 200)));
    rx_hold_seq <= rx_hold_seq + 1;
    run_random(110);

    // timeout disabled and zero speed
    settle();
    set_regs(8'd128, 8'd0, 16'hFFFF);
    run_random(60);

    // last random settings, then both sides at full rate
    settle();
    set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             16'($urandom_range(50, 1000)));
    run_random(60);
    tx_flat = 1'b1;
    rx_flat <= 1'b1;
    run_random(60);
    settle();
    tx_flat = 1'b0;
    rx_flat <= 1'b0;

    $display("covered %0d result words under six register settings,", words_checked);
    $display("gap-free and long-stall traffic included; event codes seen (bit per code): %b",
             events_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/fdcg_pkg.sv
hw/rtl/framed_drive_command_guard.sv
hw/rtl/fdcg_checker.sv
dv/drive_guard_checker.sv
dv/framed_drive_command_guard_tb.sv
